// ----- rtl/core/chunky_to_planar_4plane_unit_defines.svh -----
// Assertion macros used by the converter RTL.
`ifndef CHUNKY_TO_PLANAR_4PLANE_UNIT_DEFINES_SVH
`define CHUNKY_TO_PLANAR_4PLANE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define C2P4_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c2p4 same-cycle check failed");

// Next-cycle implication, checked on every clock outside reset.
`define C2P4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c2p4 next-cycle check failed");

`endif

// ----- rtl/core/c2p4_pkg.sv -----
package c2p4_pkg;

    // Width of the internal planar buffer address arithmetic.
    localparam int ADDR_W = 24;

    // Field widths fixed by the interface.
    localparam int PIXEL_W = 4;
    localparam int BYTE_W = 8;
    localparam int OUT_ADDR_W = 24;
    localparam int LEN_W = 24;
    localparam int DIM_W = 13;
    localparam int GROUP_W = 24;
    localparam int NPLANES = 4;

    // Stream and register port widths.
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = BYTE_W + OUT_ADDR_W;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register indexes in the configuration map.
    typedef enum logic [1:0] {
        REG_LAYOUT = 2'd0,
        REG_LENGTH = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    // Layout mode codes.
    localparam logic MODE_WHOLE = 1'b0;
    localparam logic MODE_INTERLEAVED = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0] LENGTH_RESET = 24'd32000;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd200;

    // Pixel phase of the eighth pixel of a group.
    localparam logic [2:0] PHASE_LAST = 3'd7;
    // Index of the last plane byte of a group.
    localparam logic [1:0] PLANE_LAST = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

// ----- rtl/core/chunky_to_planar_4plane_unit.sv -----
// Chunky-to-planar converter for four bitplanes.
// Input stream (s_axis_*): one 4-bit pixel per request in tdata[3:0]; bit k goes to plane k.
// Output stream (m_axis_*): per eight accepted pixels, four requests carrying plane
// bytes 0..3 with their buffer addresses; tlast marks the plane 3 byte and tuser marks
// the final byte of a frame. Frame counters then restart at zero.
// Configuration (APB): layout mode, buffer length, image width, image height at byte
// addresses 0, 4, 8, 12; write only while the stream is idle.
// Throughput: one pixel per cycle while the receiver keeps up. The eighth pixel of a group
// loads a four-entry group buffer; its bytes leave one per cycle while the receiver takes
// them, so the buffer drains well within the next eight pixels. The first plane byte is
// presented in the cycle after the eighth pixel.
// When the frame has zero groups, pixels are accepted and dropped.
// If the receiver stalls, the buffer holds its bytes; input keeps flowing until the
// eighth pixel of the next group, which waits while the buffer is still occupied.
// Reset (synchronous, active low) restores register defaults, clears the shift
// registers and counters, and empties the group buffer.
`include "chunky_to_planar_4plane_unit_defines.svh"

module chunky_to_planar_4plane_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pixel stream; tdata: pixel [3:0], zero [7:4].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [c2p4_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Plane byte stream; tdata: plane_byte [7:0], byte_address [31:8].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [c2p4_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // tuser: frame_end [0].
    output logic                                m_axis_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [c2p4_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [c2p4_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [c2p4_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import c2p4_pkg::*;

    // Configuration registers.
    logic                r_mode;
    logic [LEN_W-1:0]    r_length;
    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;

    // Conversion state.
    logic [BYTE_W-1:0]   r_shift [NPLANES];
    logic [2:0]          r_phase;
    logic [GROUP_W-1:0]  r_group;
    logic [DIM_W-1:0]    r_line;
    t_addr               r_line_base;

    // Group buffer feeding the output.
    logic                r_grp_valid;
    logic [1:0]          r_idx;
    logic [BYTE_W-1:0]   r_bytes [NPLANES];
    t_addr               r_addrs [NPLANES];
    logic                r_fend;

    // Combinational values.
    t_reg_idx            wr_idx;
    logic                cfg_wr;
    logic                in_acc;
    logic                out_acc;
    logic                interleaved;
    logic [11:0]         step;
    logic [22:0]         half;
    logic [21:0]         quarter;
    logic [GROUP_W-1:0]  groups;
    logic                empty_frame;
    logic                grp_done;
    logic                line_end;
    logic                frame_end;
    logic [BYTE_W-1:0]   n_shift [NPLANES];
    t_addr               base_addr;
    t_addr               ofs [NPLANES];

    // APB decode; the port never stalls.
    assign pready = 1'b1;
    assign wr_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (wr_idx)
            REG_LAYOUT: prdata = APB_DATA_W'(r_mode);
            REG_LENGTH: prdata = APB_DATA_W'(r_length);
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WHOLE;
            r_length <= LENGTH_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_LAYOUT: r_mode   <= pwdata[0];
                REG_LENGTH: r_length <= pwdata[LEN_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Frame geometry: plane offsets and group count for the current layout.
    always_comb begin
        interleaved = (r_mode == MODE_INTERLEAVED);
        step = r_width[DIM_W-1:1];
        if (interleaved) begin
            half   = 23'(step[11:1]);
            groups = GROUP_W'(r_width[DIM_W-1:3]);
            if (r_height == '0) begin
                groups = '0;
            end
        end else begin
            half   = r_length[LEN_W-1:1];
            groups = GROUP_W'(r_length[LEN_W-1:2]);
        end
        quarter = half[22:1];
        empty_frame = (groups == '0);
    end

    // Handshakes: only the eighth pixel of a group needs room in the group buffer.
    assign s_axis_tready = empty_frame || (r_phase != PHASE_LAST) || !r_grp_valid;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign grp_done = in_acc && !empty_frame && (r_phase == PHASE_LAST);

    // Next shift register contents and group position flags.
    always_comb begin
        for (int k = 0; k < NPLANES; k++) begin
            n_shift[k] = {r_shift[k][BYTE_W-2:0], s_axis_tdata[k]};
        end
        line_end = ({1'b0, r_group} + 25'd1) >= {1'b0, groups};
        if (interleaved) begin
            frame_end = line_end && (({1'b0, r_line} + 14'd1) >= {1'b0, r_height});
        end else begin
            frame_end = line_end;
        end
        base_addr = r_line_base + ADDR_W'(r_group);
        ofs[0] = '0;
        ofs[1] = ADDR_W'(quarter);
        ofs[2] = ADDR_W'(half);
        ofs[3] = ADDR_W'(quarter) + ADDR_W'(half);
    end

    // Shift registers and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPLANES; k++) begin
                r_shift[k] <= '0;
            end
            r_phase     <= '0;
            r_group     <= '0;
            r_line      <= '0;
            r_line_base <= '0;
        end else if (in_acc && !empty_frame) begin
            r_shift <= n_shift;
            r_phase <= r_phase + 3'd1;
            if (r_phase == PHASE_LAST) begin
                if (frame_end) begin
                    r_group     <= '0;
                    r_line      <= '0;
                    r_line_base <= '0;
                end else if (line_end && interleaved) begin
                    r_group     <= '0;
                    r_line      <= r_line + DIM_W'(1);
                    r_line_base <= r_line_base + ADDR_W'(step);
                end else begin
                    r_group <= r_group + GROUP_W'(1);
                end
            end
        end
    end

    // Group buffer: loaded by the eighth pixel, drained one plane byte per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= '0;
        end else if (grp_done) begin
            r_grp_valid <= 1'b1;
            r_idx       <= '0;
        end else if (out_acc) begin
            r_idx <= r_idx + 2'd1;
            if (r_idx == PLANE_LAST) begin
                r_grp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_done) begin
            r_bytes <= n_shift;
            for (int k = 0; k < NPLANES; k++) begin
                r_addrs[k] <= base_addr + ofs[k];
            end
            r_fend <= frame_end;
        end
    end

    // Output stream.
    assign m_axis_tvalid = r_grp_valid;
    assign m_axis_tdata  = {OUT_ADDR_W'(r_addrs[r_idx]), r_bytes[r_idx]};
    assign m_axis_tlast  = (r_idx == PLANE_LAST);
    assign m_axis_tuser  = (r_idx == PLANE_LAST) && r_fend;

    // Frame end only ever rides on the last byte of a group.
    `C2P4_ASSERT_NOW(a_fend_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // A completed group is presented on the next cycle, starting with plane 0.
    `C2P4_ASSERT_NEXT(a_group_loads, grp_done, m_axis_tvalid && (r_idx == 2'd0))
    // The buffer empties after the plane 3 byte is taken.
    `C2P4_ASSERT_NEXT(a_buffer_frees, out_acc && m_axis_tlast, !m_axis_tvalid)
    // Input only waits on an eighth pixel held back by a full buffer.
    `C2P4_ASSERT_NOW(a_stall_reason, !s_axis_tready,
                     (r_phase == PHASE_LAST) && r_grp_valid && !empty_frame)

endmodule
